@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the throughput estimator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ewma_pkg.sv @@
// ----------------------------------------------------------------------------
// ewma_pkg
// Widths, constants and shared types of the EWMA throughput estimator.
// ----------------------------------------------------------------------------
package ewma_pkg;

  // Field widths
  localparam int CMD_W   = 1;
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 32;
  localparam int TPS_W   = 20;
  localparam int BYTE_W  = 40;
  localparam int RATE_W  = 48;
  localparam int FRAC_W  = 8;

  // Product bytes * 8 * ticks_per_second
  localparam int NUM_W   = BYTE_W + 3 + TPS_W;
  // Quotient bits produced one per step
  localparam int DIV_STEPS = RATE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  // Bits of the product above the quotient range (overflow check)
  localparam int HI_W      = NUM_W - (RATE_W - FRAC_W);

  // Divide-by-five pass: one byte a cycle over a padded word
  localparam int BLEND_W   = RATE_W + 3;
  localparam int D5_W      = 56;
  localparam int D5_STEPS  = D5_W / 8;
  localparam int D5CNT_W   = $clog2(D5_STEPS);

  // APB
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TPS = 1'b0;   // paddr[2] of ticks_per_second

  // Constants
  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
  localparam logic [RATE_W-1:0] RATE_INIT = RATE_W'(100000) << FRAC_W;
  localparam logic [RATE_W-1:0] RATE_MIN  = RATE_W'(1) << FRAC_W;
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
  localparam logic [BYTE_W-1:0] BYTE_MAX  = {BYTE_W{1'b1}};

  // Commands
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_LAUNCH = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_DIV5   = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // Divider status
  typedef struct packed {
    logic done;   // one-cycle pulse, quotient valid
    logic sat;    // quotient would not fit, saturate
  } div_stat_t;

endpackage

@@ src/ewma_divider.sv @@
// ----------------------------------------------------------------------------
// ewma_divider
// Restoring divider: floor(dividend * 256 / divisor), one quotient bit per
// cycle, with overflow detection against the 48-bit rate range.
// ----------------------------------------------------------------------------
module ewma_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ewma_pkg::NUM_W-1:0]         dividend,
  input  logic [ewma_pkg::TIME_W-1:0]        divisor,
  output ewma_pkg::div_stat_t                stat,
  output logic [ewma_pkg::RATE_W-1:0]        quotient
);
  import ewma_pkg::*;

  logic              busy;
  logic              done;
  logic              sat;
  logic [DCNT_W-1:0] count;
  logic [TIME_W-1:0] rem;
  logic [RATE_W-1:0] shreg;

  logic [TIME_W-1:0] hi_ext;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  // Top of the scaled dividend; quotient overflows when it reaches divisor
  assign hi_ext = TIME_W'(dividend[NUM_W-1 -: HI_W]);

  // One restoring step
  always_comb begin
    trial = {rem, shreg[RATE_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hi_ext >= divisor) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      sat   <= (hi_ext >= divisor);
      rem   <= hi_ext;
      shreg <= {dividend[RATE_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      count <= DCNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      rem   <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      shreg <= {shreg[RATE_W-2:0], ge};
      count <= count - DCNT_W'(1);
    end
  end

  assign stat.done = done;
  assign stat.sat  = sat;
  assign quotient  = shreg;

endmodule

@@ src/ewma_throughput_estimator_top.sv @@
// ----------------------------------------------------------------------------
// ewma_throughput_estimator_top
// EWMA throughput estimator: byte accumulator and smoothed rate update.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    cmd, sent_bytes, now_time
// out      source     out_valid/out_ready  average_rate, pending_bytes
// cfg      APB slave  psel/penable/pready  ticks_per_second at byte address 0
//
// An add request updates the accumulator and goes straight to the done state;
// an update request runs one multiply, 48 restoring divider steps, the
// divide-by-five pass (one byte a cycle) and the sequencer states around them.
// in_ready is high only while the sequencer is idle; a waiting result sits in
// the output register, so the next request can start meanwhile.
// Synchronous active-high reset clears the state and the output valid flag.
// ----------------------------------------------------------------------------
module ewma_throughput_estimator_top (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ewma_pkg::CMD_W-1:0]          cmd,
  input  logic [ewma_pkg::BYTES_W-1:0]        sent_bytes,
  input  logic [ewma_pkg::TIME_W-1:0]         now_time,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ewma_pkg::RATE_W-1:0]         average_rate,
  output logic [ewma_pkg::BYTE_W-1:0]         pending_bytes,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ewma_pkg::PADDR_W-1:0]        paddr,
  input  logic [ewma_pkg::PDATA_W-1:0]        pwdata,
  output logic [ewma_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import ewma_pkg::*;

  state_t             state;
  logic [TPS_W-1:0]   tps;
  logic [BYTE_W-1:0]  byte_total;
  logic [TIME_W-1:0]  last_time;
  logic [RATE_W-1:0]  smoothed;
  logic [TIME_W-1:0]  now_reg;
  logic [TIME_W-1:0]  elapsed;
  logic [NUM_W-1:0]   num;
  logic [D5_W-1:0]    q5;
  logic [2:0]         r5;
  logic [D5CNT_W-1:0] cnt5;

  logic               in_acc;
  logic               out_free;
  logic [BYTE_W:0]    byte_sum;
  logic [RATE_W-1:0]  rate;
  logic [BLEND_W-1:0] blend_sum;
  logic [7:0]         q5_byte;
  logic [2:0]         r5_next;
  logic [RATE_W-1:0]  blended;

  div_stat_t          div_stat;
  logic [RATE_W-1:0]  div_q;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pready   = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TPS) begin
      tps <= pwdata[TPS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TPS) ? PDATA_W'(tps) : '0;

  // Saturating accumulate
  assign byte_sum = {1'b0, byte_total} + (BYTE_W+1)'(sent_bytes);

  // Saturate or take the divider quotient, then form 4*old + rate
  assign rate      = div_stat.sat ? RATE_MAX : div_q;
  assign blend_sum = {1'b0, smoothed, 2'b00} + BLEND_W'(rate);

  // Divide the top byte by five, carrying the remainder
  always_comb begin
    logic [3:0] t;
    logic [2:0] r;
    r = r5;
    for (int i = 7; i >= 0; i--) begin
      t = {r, q5[D5_W-8+i]};
      if (t >= 4'd5) begin
        q5_byte[i] = 1'b1;
        r = 3'(t - 4'd5);
      end else begin
        q5_byte[i] = 1'b0;
        r = t[2:0];
      end
    end
    r5_next = r;
  end

  // Floor at 1 bit/s
  assign blended = (q5[RATE_W-1:0] < RATE_MIN) ? RATE_MIN : q5[RATE_W-1:0];

  ewma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LAUNCH),
    .dividend (num),
    .divisor  (elapsed),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Sequencer and estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_total <= '0;
      last_time  <= '0;
      smoothed   <= RATE_INIT;
      out_valid  <= 1'b0;
    end else begin
      // Raise the result flag on a finished request, drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == CMD_ADD) begin
              byte_total <= byte_sum[BYTE_W] ? BYTE_MAX : byte_sum[BYTE_W-1:0];
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL:    state <= S_LAUNCH;
        S_LAUNCH: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DIV5;
          end
        end
        S_DIV5: begin
          if (cnt5 == D5CNT_W'(D5_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          smoothed   <= blended;
          byte_total <= '0;
          last_time  <= now_reg;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_reg <= now_time;
      elapsed <= now_time - last_time;
    end
    if (state == S_MUL) begin
      num <= NUM_W'({byte_total, 3'b000}) * NUM_W'(tps);
    end
    if (state == S_DIV && div_stat.done) begin
      q5   <= D5_W'(blend_sum);
      r5   <= '0;
      cnt5 <= '0;
    end else if (state == S_DIV5) begin
      q5   <= {q5[D5_W-9:0], q5_byte};
      r5   <= r5_next;
      cnt5 <= cnt5 + D5CNT_W'(1);
    end
    if (state == S_DONE && out_free) begin
      average_rate  <= smoothed;
      pending_bytes <= byte_total;
    end
  end

endmodule

@@ src/ewma_checker.sv @@
// ----------------------------------------------------------------------------
// ewma_checker
// Port-level checks on the throughput estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ewma_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ewma_pkg::RATE_W-1:0]  average_rate,
  input logic [ewma_pkg::BYTE_W-1:0]  pending_bytes
);
  import ewma_pkg::*;

  // Stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
            out_valid && $stable(average_rate) && $stable(pending_bytes),
            "stalled result changed")

  // An accepted request leaves in_ready low in the next cycle
  `CHK_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready,
            "ready right after a request")

  // The reported average never drops below 1 bit/s
  `CHK_IMPL(a_rate_floor, clk, rst, out_valid, average_rate >= RATE_MIN, "average below floor")

  // Reset leaves the block idle with no result pending
  `CHK_IMPL(a_reset_idle, clk, rst, $past(rst), !out_valid && in_ready, "not idle after reset")

endmodule

bind ewma_throughput_estimator_top ewma_checker u_ewma_checker (.*);
